// ===== sv/tt_pkg.sv =====
// ----------------------------------------------------------------------------
// tt_pkg
// types and constants shared by the trickle timer modules
// ----------------------------------------------------------------------------
package tt_pkg;

  // apb address width: three 32-bit registers at byte offsets 0, 4 and 8
  localparam int PADDR_W = 4;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MIN_EXP    = 2'd0;
  localparam logic [1:0] REG_DOUBLINGS  = 2'd1;
  localparam logic [1:0] REG_REDUNDANCY = 2'd2;

  // register reset values
  localparam logic [4:0] MIN_EXP_RST    = 5'd3;
  localparam logic [4:0] DOUBLINGS_RST  = 5'd20;
  localparam logic [7:0] REDUNDANCY_RST = 8'd10;

  // longest interval, 2^31 ms
  localparam logic [31:0] LEN_LIMIT = 32'h8000_0000;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [31:0] ELAPSED_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_HEARD = 2'd1,
    MODE_RESET = 2'd2,
    MODE_START = 2'd3
  } tt_mode_t;

  typedef struct packed {
    tt_mode_t    mode;
    logic [31:0] random_a;
    logic [31:0] random_b;
  } tt_in_word_t;

  typedef struct packed {
    logic        send_now;
    logic        interval_ended;
    logic [31:0] interval_now;
  } tt_out_word_t;

  typedef struct packed {
    logic [4:0] min_interval_exp;
    logic [4:0] doublings;
    logic [7:0] redundancy;
  } tt_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic decide;
    logic prep;
    logic commit;
    logic load_out;
  } tt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic rem_done;
  } tt_stat_t;

endpackage

// ===== sv/tt_regs.sv =====
// ----------------------------------------------------------------------------
// tt_regs
// apb configuration registers of the trickle timer
// ----------------------------------------------------------------------------
module tt_regs import tt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output tt_cfg_t            cfg
);

  logic [4:0] min_exp_r;
  logic [4:0] doublings_r;
  logic [7:0] redundancy_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_exp_r    <= MIN_EXP_RST;
      doublings_r  <= DOUBLINGS_RST;
      redundancy_r <= REDUNDANCY_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MIN_EXP:    min_exp_r    <= pwdata[4:0];
        REG_DOUBLINGS:  doublings_r  <= pwdata[4:0];
        REG_REDUNDANCY: redundancy_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_EXP:    prdata = {27'd0, min_exp_r};
      REG_DOUBLINGS:  prdata = {27'd0, doublings_r};
      REG_REDUNDANCY: prdata = {24'd0, redundancy_r};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg.min_interval_exp = min_exp_r;
  assign cfg.doublings        = doublings_r;
  assign cfg.redundancy       = redundancy_r;

endmodule

// ===== sv/tt_rem.sv =====
// ----------------------------------------------------------------------------
// tt_rem
// serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module tt_rem import tt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvd_r;
  logic [31:0] dsr_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] trial;

  // divisor stays below 2^31, so the partial remainder's top bit is zero
  assign trial   = {rem_r[30:0], dvd_r[31]};
  assign rem_nxt = (trial >= dsr_r) ? (trial - dsr_r) : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 32'd0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[30:0], 1'b0};
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== sv/tt_dp.sv =====
// ----------------------------------------------------------------------------
// tt_dp
// trickle timer datapath: timer state, interval arithmetic, result word
// ----------------------------------------------------------------------------
module tt_dp import tt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  tt_cfg_t      cfg,
  input  tt_in_word_t  in_word,
  input  tt_cmd_t      cmd,
  output tt_stat_t     stat,
  output tt_out_word_t out_word
);

  // captured item
  tt_mode_t    mode_r;
  logic [31:0] ra_r;
  logic [31:0] rb_r;

  // timer state
  logic        running_r, running_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] fire_r, fire_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [15:0] count_r, count_nxt;

  // work registers
  logic [31:0] len_pend_r;
  logic [31:0] half_r;
  logic        send_r;
  logic        ended_r;
  tt_out_word_t out_r;

  logic [31:0] imin;
  logic [5:0]  mask_sh;
  logic [31:0] ra_low;
  logic [32:0] start_sum;
  logic [31:0] start_len;
  logic [5:0]  cap_exp;
  logic [31:0] cap;
  logic [31:0] doubled;
  logic [31:0] grown_len;
  logic [31:0] elapsed_inc;
  logic        tick_run;
  logic        fire_hit;
  logic        below_k;
  logic        ends;
  logic [31:0] new_len;
  logic [31:0] span;
  logic        rem_done;
  logic [31:0] rem;
  logic [31:0] fire_sum;

  // interval candidates
  assign imin      = 32'd1 << cfg.min_interval_exp;
  assign mask_sh   = {1'b0, cfg.min_interval_exp} + 6'd2;
  assign ra_low    = ra_r & ~(32'hFFFF_FFFF << mask_sh);
  assign start_sum = {1'b0, imin} + {1'b0, ra_low};
  assign start_len = (start_sum > {1'b0, LEN_LIMIT}) ? LEN_LIMIT : start_sum[31:0];

  assign cap_exp   = {1'b0, cfg.min_interval_exp} + {1'b0, cfg.doublings};
  assign cap       = (cap_exp >= 6'd31) ? LEN_LIMIT : (32'd1 << cap_exp[4:0]);
  assign doubled   = {len_r[30:0], 1'b0};
  assign grown_len = ((doubled == 32'd0) || (doubled > cap)) ? cap : doubled;

  // tick decision
  assign tick_run    = (mode_r == MODE_TICK) && running_r;
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : (elapsed_r + 32'd1);
  assign below_k     = (count_r < {8'd0, cfg.redundancy}) || (cfg.redundancy == 8'd0);
  assign fire_hit    = (elapsed_inc == fire_r) && below_k;
  assign ends        = elapsed_inc >= len_r;

  always_comb begin
    case (mode_r)
      MODE_RESET: new_len = imin;
      MODE_START: new_len = start_len;
      default:    new_len = grown_len;
    endcase
  end

  assign stat.need_div = (mode_r == MODE_RESET) || (mode_r == MODE_START) ||
                         (tick_run && ends);
  assign stat.rem_done = rem_done;

  // fire point window: I/2 + (rnd mod (I - I/2 + 1))
  assign span     = {1'b0, len_pend_r[31:1]} + {31'd0, len_pend_r[0]} + 32'd1;
  assign fire_sum = half_r + rem;

  tt_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.prep),
    .dividend  (rb_r),
    .divisor   (span),
    .done      (rem_done),
    .remainder (rem)
  );

  always_comb begin
    running_nxt = running_r;
    len_nxt     = len_r;
    fire_nxt    = fire_r;
    elapsed_nxt = elapsed_r;
    count_nxt   = count_r;
    if (cmd.decide) begin
      if (tick_run) begin
        elapsed_nxt = elapsed_inc;
      end
      if ((mode_r == MODE_HEARD) && (count_r != COUNT_MAX)) begin
        count_nxt = count_r + 16'd1;
      end
    end
    if (cmd.commit) begin
      running_nxt = 1'b1;
      len_nxt     = len_pend_r;
      fire_nxt    = (fire_sum == 32'd0) ? 32'd1 : fire_sum;
      elapsed_nxt = 32'd0;
      count_nxt   = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      len_r     <= 32'd0;
      fire_r    <= 32'd0;
      elapsed_r <= 32'd0;
      count_r   <= 16'd0;
    end else begin
      running_r <= running_nxt;
      len_r     <= len_nxt;
      fire_r    <= fire_nxt;
      elapsed_r <= elapsed_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_word.mode;
      ra_r   <= in_word.random_a;
      rb_r   <= in_word.random_b;
    end
    if (cmd.decide) begin
      send_r     <= tick_run && fire_hit;
      ended_r    <= tick_run && ends;
      len_pend_r <= new_len;
    end
    if (cmd.prep) begin
      half_r <= {1'b0, len_pend_r[31:1]};
    end
    if (cmd.load_out) begin
      out_r.send_now       <= send_r;
      out_r.interval_ended <= ended_r;
      out_r.interval_now   <= len_r;
    end
  end

  assign out_word = out_r;

endmodule

// ===== sv/tt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tt_ctrl
// trickle timer sequencer and output valid
// ----------------------------------------------------------------------------
module tt_ctrl import tt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  tt_stat_t stat,
  output tt_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PREP,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd.capture  = (state_r == ST_IDLE) && in_valid;
    cmd.decide   = (state_r == ST_DECIDE);
    cmd.prep     = (state_r == ST_PREP);
    cmd.commit   = (state_r == ST_DIVIDE) && stat.rem_done;
    cmd.load_out = (state_r == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // new word staged, else the held one drains when taken
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          state_r <= stat.need_div ? ST_PREP : ST_EMIT;
        end
        ST_PREP: begin
          state_r <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (stat.rem_done) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/trickle_timer_core.sv =====
// ----------------------------------------------------------------------------
// trickle_timer_core
// trickle transmission timer counted in millisecond tick words
// ----------------------------------------------------------------------------
// sequencing: a heard word or a tick inside an interval goes accept, decide,
//   emit; start, reset or an interval end add prep and a 32-step serial remainder
// throughput: one word at a time; the next word is taken once the result is staged
// reset: synchronous active-low; timer idle, all counters zero, registers
//   back to min_interval_exp 3, doublings 20, redundancy 10
// ----------------------------------------------------------------------------
module trickle_timer_core import tt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input word channel
  input  logic               in_valid,
  output logic               in_stall,
  input  tt_in_word_t        in_word,
  // result word channel
  output logic               out_valid,
  input  logic               out_stall,
  output tt_out_word_t       out_word,
  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  tt_cfg_t  cfg;
  tt_cmd_t  cmd;
  tt_stat_t stat;

  // registers are read live by the datapath; software must write them only
  // while no word is in flight, which the block itself does not enforce
  tt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: idle -> decide -> (prep -> divide) -> emit
  // decide applies the simple updates (tick count, heard count) and tells
  // whether a new interval has to be drawn; prep loads the remainder unit
  tt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: timer state, next interval (reset to Imin, start draw, doubling
  // with cap), fire point = half interval plus random remainder, output register
  tt_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_word  (in_word),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule
